// ===== rtl/cmfd_pkg.sv =====
package cmfd_pkg;

    localparam int MOTOR_SLOTS   = 11;
    localparam int ENCODER_SLOTS = 2;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] BUS_ONE = 2'd1;
    localparam logic [1:0] BUS_TWO = 2'd2;

    localparam logic [10:0] ID_ENC_0    = 11'h001;
    localparam logic [10:0] ID_ENC_1    = 11'h002;
    localparam logic [10:0] ID_MOTOR_1  = 11'h201;
    localparam logic [10:0] ID_MOTOR_4  = 11'h204;
    localparam logic [10:0] ID_WRIST_0  = 11'h205;
    localparam logic [10:0] ID_WRIST_1  = 11'h206;
    localparam logic [10:0] ID_STRETCH  = 11'h207;

    localparam logic [3:0] ENC_FRAME_LENGTH = 4'd7;

    localparam logic [3:0] SLOT_ARM_BASE   = 4'd4;
    localparam logic [3:0] SLOT_WRIST_BASE = 4'd8;
    localparam logic [3:0] SLOT_STRETCH    = 4'd10;

    localparam logic SRC_MOTOR   = 1'b0;
    localparam logic SRC_ENCODER = 1'b1;

    typedef struct packed {
        logic [1:0]  bus_index;
        logic [10:0] frame_id;
        logic [3:0]  data_length;
        logic [55:0] payload;
    } frame_word_t;

    typedef struct packed {
        logic               source_kind;
        logic [3:0]         slot_index;
        logic [15:0]        rotor_angle;
        logic signed [15:0] speed_rpm;
        logic signed [15:0] drive_current;
        logic [7:0]         temperature;
        logic signed [31:0] turn_position;
        logic [31:0]        enc_reading;
        logic               length_error;
    } feedback_word_t;

    // classified frame waiting in the queue
    typedef struct packed {
        logic        source_kind;
        logic [3:0]  slot_index;
        logic        length_error;
        logic [55:0] payload;
    } task_word_t;

endpackage

// ===== rtl/cmfd_front.sv =====
module cmfd_front (
    input  logic                 frame_valid,
    input  cmfd_pkg::frame_word_t frame,
    input  logic                 queue_full,
    output logic                 push,
    output cmfd_pkg::task_word_t entry
);

    logic       routed;
    logic       is_enc;
    logic [3:0] slot;
    logic [10:0] id_off;
    logic [10:0] wrist_off;

    always_comb
    begin
        id_off    = frame.frame_id - cmfd_pkg::ID_MOTOR_1;
        wrist_off = frame.frame_id - cmfd_pkg::ID_WRIST_0;
        routed    = 1'b0;
        is_enc    = 1'b0;
        slot      = 4'd0;
        if (frame.bus_index == cmfd_pkg::BUS_ONE)
        begin
            if (frame.frame_id == cmfd_pkg::ID_ENC_0 || frame.frame_id == cmfd_pkg::ID_ENC_1)
            begin
                routed = 1'b1;
                is_enc = 1'b1;
                slot   = (frame.frame_id == cmfd_pkg::ID_ENC_1) ? 4'd1 : 4'd0;
            end
            else if (frame.frame_id >= cmfd_pkg::ID_MOTOR_1 &&
                     frame.frame_id <= cmfd_pkg::ID_MOTOR_4)
            begin
                routed = 1'b1;
                slot   = {2'b00, id_off[1:0]};
            end
        end
        else if (frame.bus_index == cmfd_pkg::BUS_TWO)
        begin
            if (frame.frame_id >= cmfd_pkg::ID_MOTOR_1 &&
                frame.frame_id <= cmfd_pkg::ID_MOTOR_4)
            begin
                routed = 1'b1;
                slot   = cmfd_pkg::SLOT_ARM_BASE + {2'b00, id_off[1:0]};
            end
            else if (frame.frame_id == cmfd_pkg::ID_WRIST_0 ||
                     frame.frame_id == cmfd_pkg::ID_WRIST_1)
            begin
                routed = 1'b1;
                slot   = cmfd_pkg::SLOT_WRIST_BASE + {3'b000, wrist_off[0]};
            end
            else if (frame.frame_id == cmfd_pkg::ID_STRETCH)
            begin
                routed = 1'b1;
                slot   = cmfd_pkg::SLOT_STRETCH;
            end
        end
    end

    // unrouted frames are taken and dropped
    assign push = frame_valid && !queue_full && routed;

    always_comb
    begin
        entry.source_kind  = is_enc ? cmfd_pkg::SRC_ENCODER : cmfd_pkg::SRC_MOTOR;
        entry.slot_index   = slot;
        entry.length_error = is_enc && (frame.data_length != cmfd_pkg::ENC_FRAME_LENGTH);
        entry.payload      = frame.payload;
    end

endmodule

// ===== rtl/cmfd_queue.sv =====
module cmfd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cmfd_pkg::task_word_t push_entry,
    input  logic                 pop,
    output logic                 not_empty,
    output logic                 full,
    output cmfd_pkg::task_word_t head
);

    localparam int PTR_W = $clog2(cmfd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cmfd_pkg::QUEUE_DEPTH + 1);

    cmfd_pkg::task_word_t entries_reg [cmfd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(cmfd_pkg::QUEUE_DEPTH));
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/cmfd_back.sv =====
module cmfd_back #(
    parameter int COUNTS_PER_TURN = 8192,
    parameter int POSITION_WIDTH  = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     task_valid,
    input  cmfd_pkg::task_word_t     task_entry,
    output logic                     pop,
    output logic                     feedback_valid,
    input  logic                     feedback_stall,
    output cmfd_pkg::feedback_word_t feedback
);

    localparam int SUM_W = (POSITION_WIDTH > 18) ? POSITION_WIDTH : 18;
    localparam logic signed [17:0] HALF_TURN = 18'(COUNTS_PER_TURN / 2);
    localparam logic signed [17:0] FULL_TURN = 18'(COUNTS_PER_TURN);

    logic [15:0]               prev_angle_reg [cmfd_pkg::MOTOR_SLOTS];
    logic [POSITION_WIDTH-1:0] position_reg   [cmfd_pkg::MOTOR_SLOTS];

    logic                     out_valid_reg, out_valid_next;
    cmfd_pkg::feedback_word_t out_word_reg, out_word_next;

    logic [15:0]               angle;
    logic [15:0]               raw_delta;
    logic signed [17:0]        delta;
    logic signed [SUM_W-1:0]   delta_wide;
    logic [POSITION_WIDTH-1:0] position_sum;
    logic [3:0]                slot;
    logic                      is_motor;

    assign slot     = task_entry.slot_index;
    assign is_motor = (task_entry.source_kind == cmfd_pkg::SRC_MOTOR);
    assign angle    = task_entry.payload[55:40];
    assign pop      = task_valid && (!out_valid_reg || !feedback_stall);

    always_comb
    begin
        raw_delta = angle - prev_angle_reg[slot];
        delta     = $signed({{2{raw_delta[15]}}, raw_delta});
        // fold into plus or minus half a turn
        if (delta > HALF_TURN)
        begin
            delta = delta - FULL_TURN;
        end
        else if (delta < -HALF_TURN)
        begin
            delta = delta + FULL_TURN;
        end
        delta_wide   = SUM_W'(delta);
        position_sum = position_reg[slot] + delta_wide[POSITION_WIDTH-1:0];
    end

    always_comb
    begin
        out_word_next = '0;
        out_word_next.source_kind = task_entry.source_kind;
        out_word_next.slot_index  = slot;
        if (is_motor)
        begin
            out_word_next.rotor_angle   = angle;
            out_word_next.speed_rpm     = $signed(task_entry.payload[39:24]);
            out_word_next.drive_current = $signed(task_entry.payload[23:8]);
            out_word_next.temperature   = task_entry.payload[7:0];
            out_word_next.turn_position = 32'($signed(position_sum));
        end
        else
        begin
            out_word_next.enc_reading   = {task_entry.payload[7:0],
                                           task_entry.payload[15:8],
                                           task_entry.payload[23:16],
                                           task_entry.payload[31:24]};
            out_word_next.length_error  = task_entry.length_error;
        end
        out_valid_next = pop ? 1'b1 : (out_valid_reg && feedback_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < cmfd_pkg::MOTOR_SLOTS; i++)
            begin
                prev_angle_reg[i] <= '0;
                position_reg[i]   <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop && is_motor)
            begin
                prev_angle_reg[slot] <= angle;
                position_reg[slot]   <= position_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign feedback_valid = out_valid_reg;
    assign feedback       = out_word_reg;

endmodule

// ===== rtl/can_motor_feedback_decoder_top.sv =====
// CAN motor feedback decoder.
// Frame channel: frame_valid / frame_stall / frame carry one received CAN
// frame word (bus, identifier, length, bytes 0..6). Frames on bus 1 with id
// 0x001/0x002 go to encoder slots, bus 1 ids 0x201..0x204 and bus 2 ids
// 0x201..0x207 to the eleven motor slots; every other frame is taken and
// dropped silently.
// Feedback channel: feedback_valid / feedback_stall / feedback carry one
// decoded word per routed frame, in arrival order. Motor words hold the
// unwrapped multi-turn position of the slot after this frame.
// Path: a routed frame taken on frame is written into the queue and from
// there into the output register, from which it can be taken on feedback
// when feedback is not stalled. Throughput, while feedback is not stalled,
// is one frame per cycle, set by the slot position read-modify-write.
// A two-word queue sits between the classifier and the update stage; when
// feedback stalls the output register holds, the queue fills and then
// frame_stall rises. Reset clears all slot angles and positions to zero
// and empties the queue and the output register.
module can_motor_feedback_decoder_top #(
    parameter int COUNTS_PER_TURN = 8192,
    parameter int POSITION_WIDTH  = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     frame_valid,
    output logic                     frame_stall,
    input  cmfd_pkg::frame_word_t    frame,
    output logic                     feedback_valid,
    input  logic                     feedback_stall,
    output cmfd_pkg::feedback_word_t feedback
);

    logic                 push;
    logic                 pop;
    logic                 queue_full;
    logic                 queue_not_empty;
    cmfd_pkg::task_word_t push_entry;
    cmfd_pkg::task_word_t head;

    assign frame_stall = queue_full;

    cmfd_front u_front (
        .frame_valid (frame_valid),
        .frame       (frame),
        .queue_full  (queue_full),
        .push        (push),
        .entry       (push_entry)
    );

    cmfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .full       (queue_full),
        .head       (head)
    );

    cmfd_back #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN),
        .POSITION_WIDTH  (POSITION_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .task_valid     (queue_not_empty),
        .task_entry     (head),
        .pop            (pop),
        .feedback_valid (feedback_valid),
        .feedback_stall (feedback_stall),
        .feedback       (feedback)
    );

`ifndef NO_ASSERTIONS
    a_enc_motor_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        feedback_valid && feedback.source_kind == cmfd_pkg::SRC_ENCODER |->
        feedback.rotor_angle == '0 && feedback.turn_position == '0 &&
        feedback.temperature == '0)
        else $error("encoder word carries motor fields");

    a_motor_enc_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        feedback_valid && feedback.source_kind == cmfd_pkg::SRC_MOTOR |->
        feedback.enc_reading == '0 && !feedback.length_error)
        else $error("motor word carries encoder fields");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        feedback_valid |->
        (feedback.source_kind == cmfd_pkg::SRC_MOTOR &&
         feedback.slot_index < 4'(cmfd_pkg::MOTOR_SLOTS)) ||
        (feedback.source_kind == cmfd_pkg::SRC_ENCODER &&
         feedback.slot_index < 4'(cmfd_pkg::ENCODER_SLOTS)))
        else $error("slot index out of range");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> queue_not_empty)
        else $error("update stage took a word from an empty queue");
`endif

endmodule
